@@ sv/asp_pkg.sv @@
// shared types and constants for the angular sector point test
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package asp_pkg;

  localparam int COORD_W     = 15;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int ANGLE_W     = 16;
  localparam int SCALE_SHIFT = 24;
  // scaled vector plus headroom for the cordic gain and the diagonal length
  localparam int XY_W        = DIFF_W + SCALE_SHIFT + 3;
  localparam int Z_W         = 32;
  localparam int ATAN_DEPTH  = 24;
  localparam int ATAN_IDX_W  = 5;

  localparam logic [Z_W-1:0] HALF_TURN = 32'h8000_0000;

  // round(atan(2^-i) / 2pi * 2^32)
  localparam logic [Z_W-1:0] ATAN_TABLE [ATAN_DEPTH] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // payload handed from cell to cell
  typedef struct packed {
    logic                   zero;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [Z_W-1:0]         z;
    logic [ANGLE_W-1:0]     bound_a;
    logic [ANGLE_W-1:0]     bound_b;
    logic [ANGLE_W-1:0]     reference_angle;
  } stage_t;

endpackage

@@ sv/asp_cordic_cell.sv @@
// one vectoring cordic micro-rotation with its stage register
// depends on asp_pkg
`timescale 1ns / 1ps

module asp_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           valid_in,
  input  asp_pkg::stage_t din,
  output logic           valid_out,
  output asp_pkg::stage_t dout
);
  import asp_pkg::*;

  localparam logic [Z_W-1:0] ATAN_STEP = ATAN_TABLE[ATAN_IDX_W'(STEP)];

  logic signed [XY_W-1:0] x_in;
  logic signed [XY_W-1:0] y_in;
  logic signed [XY_W-1:0] x_sh;
  logic signed [XY_W-1:0] y_sh;
  stage_t                 dout_next;

  assign x_in = din.x;
  assign y_in = din.y;
  assign x_sh = x_in >>> STEP;
  assign y_sh = y_in >>> STEP;

  always_comb begin
    dout_next = din;
    // rotate toward the x axis
    if (y_in > 0) begin
      dout_next.x = x_in + y_sh;
      dout_next.y = y_in - x_sh;
      dout_next.z = din.z + ATAN_STEP;
    end else begin
      dout_next.x = x_in - y_sh;
      dout_next.y = y_in + x_sh;
      dout_next.z = din.z - ATAN_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    dout <= dout_next;
  end

endmodule

@@ sv/asp_arc_result.sv @@
// final stage: rounds the cordic angle and tests it against the sector
// depends on asp_pkg
`timescale 1ns / 1ps

module asp_arc_result #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        valid_in,
  input  asp_pkg::stage_t             din,
  output logic                        done,
  output logic                        is_between,
  output logic [asp_pkg::ANGLE_W-1:0] point_angle
);
  import asp_pkg::*;

  localparam logic [Z_W-1:0] HALF_LSB = Z_W'(1) << (Z_W - 1 - ANGLE_BITS);

  logic [Z_W-1:0]        z_rnd;
  logic [ANGLE_BITS-1:0] angle_field;
  logic [ANGLE_W-1:0]    angle_scaled;
  logic [ANGLE_W-1:0]    angle;
  logic [ANGLE_W-1:0]    lo;
  logic [ANGLE_W-1:0]    hi;
  logic                  between_next;

  // round to nearest at ANGLE_BITS, wrapping
  assign z_rnd       = din.z + HALF_LSB;
  assign angle_field = z_rnd[Z_W-1 -: ANGLE_BITS];

  generate
    if (ANGLE_BITS >= ANGLE_W) begin : g_narrow
      assign angle_scaled = angle_field[ANGLE_BITS-1 -: ANGLE_W];
    end else begin : g_widen
      assign angle_scaled = {angle_field, {(ANGLE_W - ANGLE_BITS){1'b0}}};
    end
  endgenerate

  assign angle = din.zero ? '0 : angle_scaled;

  always_comb begin
    lo = (din.bound_b < din.bound_a) ? din.bound_b : din.bound_a;
    hi = (din.bound_b < din.bound_a) ? din.bound_a : din.bound_b;
    if (din.reference_angle > lo && din.reference_angle < hi) begin
      between_next = (angle > lo) && (angle < hi);
    end else begin
      between_next = (angle < lo) || (angle > hi);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    is_between  <= between_next;
    point_angle <= angle;
  end

endmodule

@@ sv/angular_sector_point_test.sv @@
// top level of the angular sector point test: input prep, cordic cell row, result stage
// depends on asp_pkg, asp_cordic_cell and asp_arc_result
`timescale 1ns / 1ps

// usage
//  - command channel: drive the seven fields and raise start; the item is
//    transferred at a rising edge with start high and busy low
//  - busy is high only while rst is high; otherwise a new item may be
//    transferred in every cycle, back to back
//  - result channel: done pulses for one cycle with is_between and
//    point_angle; the receiver must take it in that cycle, it cannot stall
//  - registers on the path: one prep register, one register per cordic
//    cell, one result register; throughput is one item per cycle,
//    set by the row of cordic cells each holding one item in flight
//  - results leave in transfer order, one per item
//  - synchronous reset clears the valid bits of every stage; items in flight
//    are dropped, payload registers are not cleared
//  - the y axis points down, so the vertical component is origin_y - point_y
//  - angles are binary, 65536 is a full turn; coincident points give angle 0
//  - a point exactly on a bound reports is_between low

module angular_sector_point_test #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [asp_pkg::COORD_W-1:0] origin_x,
  input  logic [asp_pkg::COORD_W-1:0] origin_y,
  input  logic [asp_pkg::COORD_W-1:0] point_x,
  input  logic [asp_pkg::COORD_W-1:0] point_y,
  input  logic [asp_pkg::ANGLE_W-1:0] bound_a,
  input  logic [asp_pkg::ANGLE_W-1:0] bound_b,
  input  logic [asp_pkg::ANGLE_W-1:0] reference_angle,
  output logic                        done,
  output logic                        is_between,
  output logic [asp_pkg::ANGLE_W-1:0] point_angle
);
  import asp_pkg::*;

  logic                     accept;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [XY_W-1:0]   x_scaled;
  logic signed [XY_W-1:0]   y_scaled;
  stage_t                   prep_next;

  // stage registers between the cells; index 0 is the prep register
  logic   stage_valid [CORDIC_STEPS+1];
  stage_t stage_data  [CORDIC_STEPS+1];

  assign busy   = rst;
  assign accept = start && !busy;

  // vector from viewpoint to point, y flipped to point up
  assign dx = $signed({1'b0, point_x}) - $signed({1'b0, origin_x});
  assign dy = $signed({1'b0, origin_y}) - $signed({1'b0, point_y});

  assign x_scaled = XY_W'(dx) <<< SCALE_SHIFT;
  assign y_scaled = XY_W'(dy) <<< SCALE_SHIFT;

  always_comb begin
    prep_next.zero            = (dx == '0) && (dy == '0);
    prep_next.bound_a         = bound_a;
    prep_next.bound_b         = bound_b;
    prep_next.reference_angle = reference_angle;
    // left half plane: turn by a half turn first
    if (dx < 0) begin
      prep_next.x = -x_scaled;
      prep_next.y = -y_scaled;
      prep_next.z = HALF_TURN;
    end else begin
      prep_next.x = x_scaled;
      prep_next.y = y_scaled;
      prep_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid[0] <= 1'b0;
    end else begin
      stage_valid[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    stage_data[0] <= prep_next;
  end

  // row of micro-rotation cells, each with its own step shift and table angle
  generate
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      asp_cordic_cell #(
        .STEP(i)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .valid_in (stage_valid[i]),
        .din      (stage_data[i]),
        .valid_out(stage_valid[i+1]),
        .dout     (stage_data[i+1])
      );
    end
  endgenerate

  asp_arc_result #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_result (
    .clk        (clk),
    .rst        (rst),
    .valid_in   (stage_valid[CORDIC_STEPS]),
    .din        (stage_data[CORDIC_STEPS]),
    .done       (done),
    .is_between (is_between),
    .point_angle(point_angle)
  );

endmodule

@@ sv/asp_checker.sv @@
// port-level checks for the angular sector point test, bound to the top level
// depends on asp_pkg and angular_sector_point_test
`timescale 1ns / 1ps

module asp_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic [asp_pkg::COORD_W-1:0] origin_x,
  input logic [asp_pkg::COORD_W-1:0] origin_y,
  input logic [asp_pkg::COORD_W-1:0] point_x,
  input logic [asp_pkg::COORD_W-1:0] point_y,
  input logic [asp_pkg::ANGLE_W-1:0] bound_a,
  input logic [asp_pkg::ANGLE_W-1:0] bound_b,
  input logic                        done,
  input logic                        is_between,
  input logic [asp_pkg::ANGLE_W-1:0] point_angle
);
  import asp_pkg::*;

  localparam int LAT = CORDIC_STEPS + 2;

  // every transfer gives a result once it has passed the prep, cell and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result missing after transfer");

  // no result without a transfer at the matching cycle
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without transfer");

  // coincident points give angle zero
  a_coincident: assert property (@(posedge clk) disable iff (rst)
    (done && $past(origin_x == point_x && origin_y == point_y, LAT))
      |-> (point_angle == '0))
    else $error("coincident points gave nonzero angle");

  // a point on a bound is never inside the arc
  a_on_bound: assert property (@(posedge clk) disable iff (rst)
    (done && (point_angle == $past(bound_a, LAT) || point_angle == $past(bound_b, LAT)))
      |-> !is_between)
    else $error("point on a bound reported inside");

endmodule

bind angular_sector_point_test asp_checker #(
  .CORDIC_STEPS(CORDIC_STEPS)
) u_asp_checker (.*);

@@ dv/asp_sector_checker.sv @@
`timescale 1ns / 1ps
// in-order checker for the angular sector point test: predicts heading and sector flag per command
// depends on asp_pkg for field widths; instantiated beside the block by the testbench top

module asp_sector_checker #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [asp_pkg::COORD_W-1:0] origin_x,
  input  logic [asp_pkg::COORD_W-1:0] origin_y,
  input  logic [asp_pkg::COORD_W-1:0] point_x,
  input  logic [asp_pkg::COORD_W-1:0] point_y,
  input  logic [asp_pkg::ANGLE_W-1:0] bound_a,
  input  logic [asp_pkg::ANGLE_W-1:0] bound_b,
  input  logic [asp_pkg::ANGLE_W-1:0] reference_angle,
  input  logic                        done,
  input  logic                        is_between,
  input  logic [asp_pkg::ANGLE_W-1:0] point_angle,
  output int unsigned                 fail_count,
  output int unsigned                 outstanding
);

  import asp_pkg::*;

  typedef struct packed {
    logic               between;
    logic [ANGLE_W-1:0] heading;
  } sector_result_t;

  // atan(2^-i) as a 32-bit binary angle
  localparam logic [31:0] ARCTAN_STEP [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  sector_result_t expected_q [$];
  int unsigned    fails = 0;
  int unsigned    in_flight = 0;
  int unsigned    result_index = 0;

  assign fail_count  = fails;
  assign outstanding = in_flight;

  // vectoring cordic heading, y already flipped to point up
  function automatic logic [ANGLE_W-1:0] heading_of(input longint dx, input longint dy);
    longint      x;
    longint      y;
    longint      nx;
    longint      ny;
    logic [31:0] z;
    logic [63:0] r;
    if (dx == 0 && dy == 0) begin
      return '0;
    end
    x = dx <<< 24;
    y = dy <<< 24;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + ARCTAN_STEP[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - ARCTAN_STEP[i];
      end
      x = nx;
      y = ny;
    end
    r = ({32'd0, z} + (64'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
    r = r & ((64'd1 << ANGLE_BITS) - 64'd1);
    r = (r << 16) >> ANGLE_BITS;
    return r[ANGLE_W-1:0];
  endfunction

  // strict containment in the arc that holds the reference
  function automatic logic sector_contains(input logic [ANGLE_W-1:0] c, a, b, r);
    logic [ANGLE_W-1:0] lo;
    logic [ANGLE_W-1:0] hi;
    lo = (b < a) ? b : a;
    hi = (b < a) ? a : b;
    if (r > lo && r < hi) begin
      return c > lo && c < hi;
    end
    return c < lo || c > hi;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want_v);
    if (fails < 100) begin
      $display("%0t ns: result %0d %s: got %0d, expected %0d",
               $time, result_index, what, got, want_v);
    end
    fails++;
  endtask

  always @(posedge clk) begin
    sector_result_t want;
    int unsigned    pushed;
    int unsigned    popped;
    pushed = 0;
    popped = 0;
    if (rst) begin
      expected_q.delete();
      in_flight <= 0;
    end else begin
      // results are taken first so a stray one is never matched to this cycle's command
      if (done) begin
        if (expected_q.size() == 0) begin
          report_mismatch("with nothing pending, point_angle", 32'(point_angle), 0);
        end else begin
          want   = expected_q.pop_front();
          popped = 1;
          if (point_angle !== want.heading) begin
            report_mismatch("point_angle", 32'(point_angle), 32'(want.heading));
          end
          if (is_between !== want.between) begin
            report_mismatch("is_between", 32'(is_between), 32'(want.between));
          end
        end
        result_index++;
      end
      if (start && !busy) begin
        want.heading = heading_of(longint'(point_x) - longint'(origin_x),
                                  longint'(origin_y) - longint'(point_y));
        want.between = sector_contains(want.heading, bound_a, bound_b, reference_angle);
        expected_q.insert(expected_q.size(), want);
        pushed = 1;
      end
      in_flight <= in_flight + pushed - popped;
    end
  end

endmodule

@@ dv/angular_sector_point_test_test.sv @@
`timescale 1ns / 1ps
// testbench top for the angular sector point test: clock, reset, command stimulus and verdict
// depends on asp_pkg, the block and asp_sector_checker, which does all prediction and comparison

module angular_sector_point_test_test;

  import asp_pkg::*;

  localparam int STEPS       = 16;
  localparam int ABITS       = 16;
  // prep register, one register per cordic cell, result register
  localparam int LATENCY     = STEPS + 2;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 142;
  localparam int COORD_MAX   = (1 << COORD_W) - 1;
  localparam int EIGHTH_TURN = 8192;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [COORD_W-1:0] origin_x = '0;
  logic [COORD_W-1:0] origin_y = '0;
  logic [COORD_W-1:0] point_x = '0;
  logic [COORD_W-1:0] point_y = '0;
  logic [ANGLE_W-1:0] bound_a = '0;
  logic [ANGLE_W-1:0] bound_b = '0;
  logic [ANGLE_W-1:0] reference_angle = '0;
  logic               busy;
  logic               done;
  logic               is_between;
  logic [ANGLE_W-1:0] point_angle;
  int unsigned        fail_count;
  int unsigned        outstanding;
  int unsigned        cycle_count = 0;
  // chance in percent that the sender idles in a given cycle
  int unsigned        idle_pct = 0;

  always #5 clk = ~clk;

  angular_sector_point_test #(
    .CORDIC_STEPS(STEPS),
    .ANGLE_BITS  (ABITS)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .origin_x       (origin_x),
    .origin_y       (origin_y),
    .point_x        (point_x),
    .point_y        (point_y),
    .bound_a        (bound_a),
    .bound_b        (bound_b),
    .reference_angle(reference_angle),
    .done           (done),
    .is_between     (is_between),
    .point_angle    (point_angle)
  );

  asp_sector_checker #(
    .CORDIC_STEPS(STEPS),
    .ANGLE_BITS  (ABITS)
  ) sector_check (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .origin_x       (origin_x),
    .origin_y       (origin_y),
    .point_x        (point_x),
    .point_y        (point_y),
    .bound_a        (bound_a),
    .bound_b        (bound_b),
    .reference_angle(reference_angle),
    .done           (done),
    .is_between     (is_between),
    .point_angle    (point_angle),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  // present one command and hold it until the transfer edge
  // start stays high on return so back-to-back commands never drop it
  task automatic send_item(input int ox, oy, px, py, input int a, b, r);
    origin_x        <= COORD_W'(ox);
    origin_y        <= COORD_W'(oy);
    point_x         <= COORD_W'(px);
    point_y         <= COORD_W'(py);
    bound_a         <= ANGLE_W'(a);
    bound_b         <= ANGLE_W'(b);
    reference_angle <= ANGLE_W'(r);
    start           <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // an idle cycle with start low and junk on the fields, which the block must ignore
  task automatic idle_cycle();
    start           <= 1'b0;
    origin_x        <= COORD_W'($urandom);
    origin_y        <= COORD_W'($urandom);
    point_x         <= COORD_W'($urandom);
    point_y         <= COORD_W'($urandom);
    bound_a         <= ANGLE_W'($urandom);
    bound_b         <= ANGLE_W'($urandom);
    reference_angle <= ANGLE_W'($urandom);
    @(posedge clk);
  endtask

  // stop sending and let every pending result come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // one random command; the mix favors the cases where the arithmetic is
  // most likely to go wrong: axes and diagonals, tiny vectors, bounds that
  // coincide with each other, with the reference or with the heading
  task automatic random_command();
    int kind;
    int dir;
    int k;
    int sx;
    int sy;
    int ox;
    int oy;
    int px;
    int py;
    int a;
    int b;
    int r;
    kind = $urandom_range(0, 9);
    ox   = $urandom_range(0, COORD_MAX);
    oy   = $urandom_range(0, COORD_MAX);
    px   = $urandom_range(0, COORD_MAX);
    py   = $urandom_range(0, COORD_MAX);
    a    = $urandom_range(0, 65535);
    b    = $urandom_range(0, 65535);
    r    = $urandom_range(0, 65535);
    case (kind)
      3, 4: begin
        // short vector around the viewpoint, clamped to the screen
        px = ox + $urandom_range(0, 16) - 8;
        py = oy + $urandom_range(0, 16) - 8;
        px = (px < 0) ? 0 : (px > COORD_MAX) ? COORD_MAX : px;
        py = (py < 0) ? 0 : (py > COORD_MAX) ? COORD_MAX : py;
      end
      5: begin
        // exact axis or diagonal, bounds on eighth turns so the heading can sit on one
        dir = $urandom_range(0, 7);
        k   = $urandom_range(1, COORD_MAX / 2);
        sx  = (dir == 0 || dir == 1 || dir == 7) ? 1 : (dir == 2 || dir == 6) ? 0 : -1;
        sy  = (dir >= 1 && dir <= 3) ? 1 : (dir == 0 || dir == 4) ? 0 : -1;
        ox  = (sx > 0) ? $urandom_range(0, COORD_MAX - k) :
              (sx < 0) ? $urandom_range(k, COORD_MAX) : ox;
        oy  = (sy > 0) ? $urandom_range(k, COORD_MAX) :
              (sy < 0) ? $urandom_range(0, COORD_MAX - k) : oy;
        px  = ox + sx * k;
        // screen y grows downward, so an upward heading lowers point_y
        py  = oy - sy * k;
        a   = ($urandom_range(0, 1) == 1) ? dir * EIGHTH_TURN :
                                            $urandom_range(0, 7) * EIGHTH_TURN;
        b   = $urandom_range(0, 7) * EIGHTH_TURN;
        if ($urandom_range(0, 1) == 1) begin
          r = $urandom_range(0, 7) * EIGHTH_TURN;
        end
      end
      6: begin
        // empty inner arc
        b = a;
      end
      7: begin
        // reference sitting on a bound
        r = ($urandom_range(0, 1) == 1) ? a : b;
      end
      8: begin
        // coincident points
        px = ox;
        py = oy;
      end
      9: begin
        // screen corners
        ox = $urandom_range(0, 1) * COORD_MAX;
        oy = $urandom_range(0, 1) * COORD_MAX;
        px = $urandom_range(0, 1) * COORD_MAX;
        py = $urandom_range(0, 1) * COORD_MAX;
      end
      default: begin
      end
    endcase
    send_item(ox, oy, px, py, a, b, r);
  endtask

  // watchdog: ends a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: the four axes, the four diagonals across the whole screen,
    // coincident points, headings exactly on a bound, equal bounds,
    // reference on either bound, wrapping arcs and swapped bounds
    send_item(0, 0, 0, 0, 0, 0, 0);
    send_item(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 65535, 0, 100);
    send_item(0, 100, COORD_MAX, 100, 0, 16384, 8192);
    send_item(5, COORD_MAX, 5, 0, 16384, 100, 200);
    send_item(COORD_MAX, 7, 0, 7, 0, 65535, 100);
    send_item(9, 0, 9, COORD_MAX, 49152, 32768, 40000);
    send_item(0, COORD_MAX, COORD_MAX, 0, 0, 16384, 8000);
    send_item(COORD_MAX, 0, 0, COORD_MAX, 32768, 49152, 40000);
    send_item(0, 0, COORD_MAX, COORD_MAX, 57344, 57344, 0);
    send_item(COORD_MAX, COORD_MAX, 0, 0, 24576, 24577, 24576);
    send_item(200, 200, 300, 200, 0, 0, 0);
    send_item(200, 200, 300, 200, 1000, 1000, 5);
    send_item(200, 200, 200, 100, 1000, 30000, 1000);
    send_item(200, 200, 200, 100, 1000, 30000, 30000);
    send_item(300, 300, 400, 300, 60000, 5000, 63000);
    send_item(300, 300, 300, 200, 50000, 10000, 30000);
    send_item(300, 300, 300, 400, 65535, 65535, 0);
    send_item(100, 100, 101, 100, 1, 65535, 0);
    send_item(100, 100, 100, 99, 16383, 16385, 16384);
    send_item(100, 100, 99, 101, 40000, 50000, 45000);
    send_item(0, COORD_MAX - 1, COORD_MAX, COORD_MAX, 65000, 100, 65535);
    send_item(COORD_MAX, 1, 0, 0, 32000, 33000, 32500);
    send_item(COORD_MAX, 0, 0, 1, 32000, 33000, 32500);

    // hold off until the pipeline is empty before the random part
    drain();

    // random phases at different sender duty, each ending with a full drain
    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 57;
        default: idle_pct = 6;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        while ($urandom_range(1, 100) <= idle_pct) idle_cycle();
        random_command();
      end
      drain();
    end

    // no command can be left without a result; the extra cycles catch stray strobes
    repeat (LATENCY + 4) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ angular_sector_point_test.f @@
sv/asp_pkg.sv
sv/asp_cordic_cell.sv
sv/asp_arc_result.sv
sv/angular_sector_point_test.sv
sv/asp_checker.sv
dv/asp_sector_checker.sv
dv/angular_sector_point_test_test.sv
